[hdl/rusm_pkg.sv]
`default_nettype none
package rusm_pkg;

	// frame geometry
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int DIM_W      = 11;
	localparam int ROW_W      = 11;

	// datapath widths
	localparam int PIX_W   = 24;
	localparam int COEF_W  = 16;
	localparam int WSUM_W  = 20;
	localparam int ACC_W   = 28;
	localparam int PROD1_W = 28;
	localparam int PROD2_W = 36;
	localparam int NUM_W   = 37;
	localparam int DEN_W   = 29;
	localparam int QUO_W   = 9;

	// register indexes
	localparam logic [2:0] REG_COEF_CENTER     = 3'd0;
	localparam logic [2:0] REG_COEF_VERTICAL   = 3'd1;
	localparam logic [2:0] REG_COEF_HORIZONTAL = 3'd2;
	localparam logic [2:0] REG_COEF_DIAGONAL   = 3'd3;
	localparam logic [2:0] REG_SHARPEN_AMOUNT  = 3'd4;
	localparam logic [2:0] REG_BORDER_MODE     = 3'd5;
	localparam logic [2:0] REG_FRAME_WIDTH     = 3'd6;
	localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd7;

	// border modes (code 3 behaves as renormalized)
	localparam logic [1:0] BM_ZERO   = 2'd0;
	localparam logic [1:0] BM_MIRROR = 2'd1;
	localparam logic [1:0] BM_RENORM = 2'd2;

	// reset values
	localparam logic [COEF_W-1:0] RST_COEF_CENTER     = 16'd13380;
	localparam logic [COEF_W-1:0] RST_COEF_VERTICAL   = 16'd8116;
	localparam logic [COEF_W-1:0] RST_COEF_HORIZONTAL = 16'd8116;
	localparam logic [COEF_W-1:0] RST_COEF_DIAGONAL   = 16'd4922;
	localparam logic [7:0]        RST_SHARPEN_AMOUNT  = 8'd128;
	localparam logic [DIM_W-1:0]  RST_FRAME_DIM       = 11'd512;

	localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

	typedef struct packed {
		logic [COEF_W-1:0] coef_center;
		logic [COEF_W-1:0] coef_vertical;
		logic [COEF_W-1:0] coef_horizontal;
		logic [COEF_W-1:0] coef_diagonal;
		logic [7:0]        sharpen_amount;
		logic [1:0]        border_mode;
		logic [DIM_W-1:0]  frame_width;
		logic [DIM_W-1:0]  frame_height;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic upd;
		logic mac;
		logic num1;
		logic num2;
		logic div;
		logic load;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic act;
		logic emit;
		logic tap_last;
		logic div_last;
		logic out_free;
	} dp_sts_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (v < DIM_W'(2)) r = DIM_W'(2);
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/rusm_ram.sv]
`default_nettype none
module rusm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[hdl/rusm_ctrl.sv]
`default_nettype none
module rusm_ctrl
	import rusm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_NUM1 = 3'd3;
	localparam logic [2:0] ST_NUM2 = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q, state_d;

	// commands
	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.upd    = (state_q == ST_UPD);
		cmd.mac    = (state_q == ST_MAC);
		cmd.num1   = (state_q == ST_NUM1);
		cmd.num2   = (state_q == ST_NUM2);
		cmd.div    = (state_q == ST_DIV);
		cmd.load   = (state_q == ST_OUT) && sts.out_free;
	end

	assign in_stall = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.act) state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = sts.emit ? ST_MAC : ST_IDLE;
			end
			ST_MAC: begin
				if (sts.tap_last) state_d = ST_NUM1;
			end
			ST_NUM1: state_d = ST_NUM2;
			ST_NUM2: state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && sts.div_last) |=> (state_q == ST_OUT))
		else $error("divider end did not reach output state");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD && !sts.emit) |=> (state_q == ST_IDLE))
		else $error("item without result did not return to idle");

	a_mac_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC && !sts.tap_last) |=> (state_q == ST_MAC))
		else $error("tap sweep left early");

endmodule
`default_nettype wire

[hdl/rusm_datapath.sv]
`default_nettype none
module rusm_datapath
	import rusm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts,
	input  wire logic    kind,
	input  wire logic [7:0] in_red,
	input  wire logic [7:0] in_green,
	input  wire logic [7:0] in_blue,
	input  wire logic    out_stall,
	output logic         out_valid,
	output logic [7:0]   out_red,
	output logic [7:0]   out_green,
	output logic [7:0]   out_blue,
	output logic         frame_end
);

	// position and latched frame size
	logic [ROW_W-1:0] ir_q;
	logic [COL_W-1:0] ic_q;
	logic [DIM_W-1:0] lat_w_q, lat_h_q;

	// item captured for the window update
	logic [PIX_W-1:0] pix_q;
	logic [COL_W-1:0] ic_wr_q;
	logic             emit_q, pre_q, fe_q;
	logic             top_in_q, bot_in_q, left_in_q, right_in_q;

	// window, tap snapshot, line store read data
	logic [PIX_W-1:0] win_q [9];
	logic [PIX_W-1:0] tp_q [9];
	logic [PIX_W-1:0] older_rd, newer_rd;

	// tap sweep
	logic [1:0]        tr_q, tc_q;
	logic [ACC_W-1:0]  s_q [3];
	logic [WSUM_W-1:0] wt_q;

	// numerator / denominator and divider
	logic [PROD1_W-1:0] p1_q [3];
	logic [PROD2_W-1:0] p2_q [3];
	logic [DEN_W-1:0]   den_q;
	logic [NUM_W-1:0]   rem_q [3];
	logic               neg_q [3];
	logic [QUO_W-1:0]   q_q [3];
	logic [3:0]         k_q;

	// ---------------- accept decode ----------------
	logic             latch;
	logic [DIM_W-1:0] eff_w, eff_h;
	logic             row_live, emit_pre, emit_post, fe_n, wrap;
	logic [COL_W-1:0] orow_n, ocol_n;
	logic [ROW_W-1:0] ir_m1, ir_m2;
	logic [DIM_W-1:0] w_m1, ic_inc;

	always_comb begin
		latch     = (ir_q == '0) && (ic_q == '0) && !kind;
		eff_w     = latch ? clamp_dim(cfg.frame_width, MAX_W_DIM) : lat_w_q;
		eff_h     = latch ? clamp_dim(cfg.frame_height, MAX_H_DIM) : lat_h_q;
		row_live  = ir_q < eff_h;
		emit_pre  = (ic_q == '0) && (ir_q >= ROW_W'(2));
		emit_post = (ic_q != '0) && (ir_q >= ROW_W'(1));
		ir_m1     = ir_q - ROW_W'(1);
		ir_m2     = ir_q - ROW_W'(2);
		w_m1      = eff_w - DIM_W'(1);
		orow_n    = emit_pre ? ir_m2[COL_W-1:0] : ir_m1[COL_W-1:0];
		ocol_n    = emit_pre ? w_m1[COL_W-1:0] : (ic_q - COL_W'(1));
		fe_n      = (emit_pre || emit_post) && ({1'b0, orow_n} == eff_h - DIM_W'(1))
			&& ({1'b0, ocol_n} == w_m1);
		ic_inc    = {1'b0, ic_q} + DIM_W'(1);
		wrap      = ic_inc >= eff_w;
	end

	assign sts.act  = !(row_live && kind);
	assign sts.emit = emit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_q    <= '0;
			ic_q    <= '0;
			lat_w_q <= RST_FRAME_DIM;
			lat_h_q <= RST_FRAME_DIM;
			emit_q  <= 1'b0;
		end else if (cmd.accept && sts.act) begin
			lat_w_q <= eff_w;
			lat_h_q <= eff_h;
			emit_q  <= emit_pre || emit_post;
			if (fe_n) begin
				ir_q <= '0;
				ic_q <= '0;
			end else if (wrap) begin
				ir_q <= ir_q + ROW_W'(1);
				ic_q <= '0;
			end else begin
				ic_q <= ic_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.act) begin
			pix_q      <= row_live ? {in_blue, in_green, in_red} : '0;
			ic_wr_q    <= ic_q;
			pre_q      <= emit_pre;
			fe_q       <= fe_n;
			top_in_q   <= orow_n != '0;
			bot_in_q   <= ({1'b0, orow_n} + DIM_W'(1)) < eff_h;
			left_in_q  <= ocol_n != '0;
			right_in_q <= ({1'b0, ocol_n} + DIM_W'(1)) < eff_w;
		end
	end

	// ---------------- line stores ----------------
	rusm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (ic_wr_q),
		.wdata (newer_rd),
		.raddr (ic_q),
		.rdata (older_rd)
	);

	rusm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
		.clk   (clk),
		.we    (cmd.upd),
		.waddr (ic_wr_q),
		.wdata (pix_q),
		.raddr (ic_q),
		.rdata (newer_rd)
	);

	// ---------------- window shift and tap snapshot ----------------
	logic [PIX_W-1:0] col_new [3];
	assign col_new[0] = older_rd;
	assign col_new[1] = newer_rd;
	assign col_new[2] = pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (cmd.upd) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= win_q[r*3 + 1];
				win_q[r*3 + 1] <= win_q[r*3 + 2];
				win_q[r*3 + 2] <= col_new[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			for (int r = 0; r < 3; r++) begin
				tp_q[r*3]     <= win_q[r*3 + 1];
				tp_q[r*3 + 1] <= win_q[r*3 + 2];
				tp_q[r*3 + 2] <= pre_q ? '0 : col_new[r];
			end
		end
	end

	// ---------------- tap sweep, one tap per cycle ----------------
	function automatic logic [3:0] tidx(input logic [1:0] r, input logic [1:0] c);
		return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
	endfunction

	logic              mirror, renorm, row_in, col_in, use_tap;
	logic [1:0]        sr, sc;
	logic [COEF_W-1:0] wgt;
	logic [PIX_W-1:0]  sel_pix;

	always_comb begin
		mirror = cfg.border_mode == BM_MIRROR;
		renorm = (cfg.border_mode != BM_ZERO) && (cfg.border_mode != BM_MIRROR);
		row_in = (tr_q == 2'd0) ? top_in_q : (tr_q == 2'd2) ? bot_in_q : 1'b1;
		col_in = (tc_q == 2'd0) ? left_in_q : (tc_q == 2'd2) ? right_in_q : 1'b1;
		// mirror reflects an outside row or column onto the opposite tap
		sr = (tr_q == 2'd0 && !top_in_q) ? 2'd2 : (tr_q == 2'd2 && !bot_in_q) ? 2'd0 : tr_q;
		sc = (tc_q == 2'd0 && !left_in_q) ? 2'd2
			: (tc_q == 2'd2 && !right_in_q) ? 2'd0 : tc_q;
		use_tap = mirror || (row_in && col_in);
		sel_pix = mirror ? tp_q[tidx(sr, sc)] : tp_q[tidx(tr_q, tc_q)];
		if (tr_q == 2'd1 && tc_q == 2'd1) wgt = cfg.coef_center;
		else if (tc_q == 2'd1)           wgt = cfg.coef_vertical;
		else if (tr_q == 2'd1)           wgt = cfg.coef_horizontal;
		else                             wgt = cfg.coef_diagonal;
	end

	assign sts.tap_last = (tr_q == 2'd2) && (tc_q == 2'd2);

	logic [PIX_W-1:0] prod [3];
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = wgt * sel_pix[8*ch +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_q <= '0;
			tc_q <= '0;
		end else if (cmd.upd) begin
			tr_q <= '0;
			tc_q <= '0;
		end else if (cmd.mac) begin
			if (tc_q == 2'd2) begin
				tc_q <= '0;
				tr_q <= tr_q + 2'd1;
			end else begin
				tc_q <= tc_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			wt_q <= '0;
			for (int ch = 0; ch < 3; ch++) s_q[ch] <= '0;
		end else if (cmd.mac && use_tap) begin
			wt_q <= wt_q + WSUM_W'(wgt);
			for (int ch = 0; ch < 3; ch++) s_q[ch] <= s_q[ch] + ACC_W'(prod[ch]);
		end
	end

	// ---------------- numerator and denominator ----------------
	// num = c*256*W - a*S, den = W*(256-a); W is 65536 or the in-frame weight total
	logic [WSUM_W-1:0] w_use;
	logic [8:0]        one_minus_a;
	logic [NUM_W-1:0]  num [3];

	always_comb begin
		if (!renorm)            w_use = WSUM_W'(65536);
		else if (wt_q == '0)    w_use = WSUM_W'(1);
		else                    w_use = wt_q;
		one_minus_a = 9'd256 - {1'b0, cfg.sharpen_amount};
		for (int ch = 0; ch < 3; ch++) begin
			num[ch] = {1'b0, p1_q[ch], 8'b0} - {1'b0, p2_q[ch]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.num1) begin
			den_q <= w_use * one_minus_a;
			for (int ch = 0; ch < 3; ch++) begin
				p1_q[ch] <= tp_q[4][8*ch +: 8] * w_use;
				p2_q[ch] <= cfg.sharpen_amount * s_q[ch];
			end
		end
	end

	// ---------------- restoring divider, one quotient bit per cycle ----------------
	logic [NUM_W:0] dsh;
	logic [NUM_W:0] diff [3];

	always_comb begin
		dsh = {9'b0, den_q} << k_q;
		for (int ch = 0; ch < 3; ch++) begin
			diff[ch] = {1'b0, rem_q[ch]} - dsh;
		end
	end

	assign sts.div_last = (k_q == 4'd0);

	always_ff @(posedge clk) begin
		if (cmd.num2) begin
			k_q <= 4'd8;
			for (int ch = 0; ch < 3; ch++) begin
				rem_q[ch] <= num[ch];
				neg_q[ch] <= num[ch][NUM_W-1];
				q_q[ch]   <= '0;
			end
		end else if (cmd.div) begin
			k_q <= k_q - 4'd1;
			for (int ch = 0; ch < 3; ch++) begin
				if (!diff[ch][NUM_W]) begin
					rem_q[ch]     <= diff[ch][NUM_W-1:0];
					q_q[ch][k_q] <= 1'b1;
				end
			end
		end
	end

	// ---------------- output register ----------------
	logic [7:0] res [3];
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			if (neg_q[ch])          res[ch] = 8'd1;
			else if (q_q[ch][8])    res[ch] = 8'd255;
			else                    res[ch] = q_q[ch][7:0];
		end
	end

	assign sts.out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_red   <= res[0];
			out_green <= res[1];
			out_blue  <= res[2];
			frame_end <= fe_q;
		end
	end

endmodule
`default_nettype wire

[hdl/rgb_unsharp_mask_3x3.sv]
// 3x3 unsharp mask for a raster stream of 24-bit RGB pixels.
// Input channel: in_valid/in_stall with kind, in_red, in_green, in_blue. kind 0 is a
// frame pixel, kind 1 a drain item; after the last pixel of a frame send frame_width+1
// drain items to push out the final row. Pixel items of the next frame sent while the
// previous one still drains are used as drain items.
// Output channel: out_valid/out_stall with out_red, out_green, out_blue, frame_end.
// Each result belongs to the pixel one row and one column before the current input.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index, cfg_data; write only
// while idle. Frame size is latched at a frame's first pixel.
// Timing: an item that gives no result takes a line store read, then a window update. An
// item with a result takes the update, tap multiply-accumulate (one tap per cycle),
// numerator and denominator, the restoring divider (one quotient bit per cycle), then
// the load into the output register. in_stall is high during this sequence.
// The output register holds one result; while it is stalled the next result waits in
// the divider and the input stays stalled. Reset clears counters and the window, sets
// registers to their defaults; the line stores are not cleared.
`default_nettype none
module rgb_unsharp_mask_3x3
	import rusm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        kind,
	input  wire logic [7:0]  in_red,
	input  wire logic [7:0]  in_green,
	input  wire logic [7:0]  in_blue,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_red,
	output logic [7:0]       out_green,
	output logic [7:0]       out_blue,
	output logic             frame_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t    cfg_q;
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_center     <= RST_COEF_CENTER;
			cfg_q.coef_vertical   <= RST_COEF_VERTICAL;
			cfg_q.coef_horizontal <= RST_COEF_HORIZONTAL;
			cfg_q.coef_diagonal   <= RST_COEF_DIAGONAL;
			cfg_q.sharpen_amount  <= RST_SHARPEN_AMOUNT;
			cfg_q.border_mode     <= BM_RENORM;
			cfg_q.frame_width     <= RST_FRAME_DIM;
			cfg_q.frame_height    <= RST_FRAME_DIM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COEF_CENTER:     cfg_q.coef_center     <= cfg_data;
				REG_COEF_VERTICAL:   cfg_q.coef_vertical   <= cfg_data;
				REG_COEF_HORIZONTAL: cfg_q.coef_horizontal <= cfg_data;
				REG_COEF_DIAGONAL:   cfg_q.coef_diagonal   <= cfg_data;
				REG_SHARPEN_AMOUNT:  cfg_q.sharpen_amount  <= cfg_data[7:0];
				REG_BORDER_MODE:     cfg_q.border_mode     <= cfg_data[1:0];
				REG_FRAME_WIDTH:     cfg_q.frame_width     <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT:    cfg_q.frame_height    <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	rusm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rusm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.frame_end (frame_end)
	);

endmodule
`default_nettype wire
